// ===== sv/rk4_pkg.sv =====
// Shared types and constants for the RK4 stage update block.
// Used by the coefficient unit, the point pipeline and the top level.
// No dependencies.
package rk4_pkg;

  localparam int DATA_W = 32;
  localparam int COEF_W = 31;
  localparam int IDX_W  = 10;

  localparam int MAX_POINTS_DEF    = 1024;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [COEF_W-1:0] STEP_RESET = 31'd65536;

  // floor(n / 3) = (n * RECIP3) >> RECIP3_SHIFT, exact for any 32-bit n
  localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;
  localparam int          RECIP3_SHIFT = 33;

  // cycles from a step_size write until the coefficients are settled
  localparam int CFG_LATENCY = 2;

  typedef enum logic [1:0] {
    ACT_PRED1 = 2'd0,
    ACT_CORR1 = 2'd1,
    ACT_PRED2 = 2'd2,
    ACT_CORR2 = 2'd3
  } action_t;

  typedef struct packed {
    logic [COEF_W-1:0] c6;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c1;
  } coef_t;

endpackage

// ===== sv/rk4_coef.sv =====
// Step size register and derivation of dt/6, dt/3, dt/2 and dt.
// Depends on rk4_pkg (coef_t, reciprocal constants, reset step).
module rk4_coef (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wen,
  input  logic [rk4_pkg::COEF_W-1:0]   wdata,
  output rk4_pkg::coef_t               coef,
  output logic                         busy
);

  logic [rk4_pkg::COEF_W-1:0]      dt;
  logic [rk4_pkg::CFG_LATENCY-1:0] pend;
  logic [63:0]                     p6;
  logic [63:0]                     p3;
  logic [31:0]                     n6;
  logic [31:0]                     n3;

  // c6 = floor(floor((dt+3)/2)/3), c3 = floor((dt+1)/3)
  assign n6   = ({1'b0, dt} + 32'd3) >> 1;
  assign n3   = {1'b0, dt} + 32'd1;
  assign busy = (pend != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      dt   <= rk4_pkg::STEP_RESET;
      pend <= '1;
    end else if (wen) begin
      dt   <= wdata;
      pend <= '1;
    end else begin
      pend <= pend >> 1;
    end
  end

  // free-running: p6 and p3 are registered, then c6 and c3; c2 and c1 register from dt
  always_ff @(posedge clk) begin
    p6      <= 64'(n6) * 64'(rk4_pkg::RECIP3);
    p3      <= 64'(n3) * 64'(rk4_pkg::RECIP3);
    coef.c6 <= p6[rk4_pkg::RECIP3_SHIFT +: rk4_pkg::COEF_W];
    coef.c3 <= p3[rk4_pkg::RECIP3_SHIFT +: rk4_pkg::COEF_W];
    coef.c2 <= n3[rk4_pkg::COEF_W:1];
    coef.c1 <= dt;
  end

endmodule

// ===== sv/rk4_mem.sv =====
// Per-point stores: start value and slope accumulator, one write and one read port.
// Read data is registered. Depends on no package items.
module rk4_mem #(
  parameter int MAX_POINTS = 1024,
  parameter int ADDR_W     = 10
) (
  input  logic              clk,
  input  logic              ren,
  input  logic [ADDR_W-1:0] raddr,
  output logic [63:0]       rd_st,
  output logic [63:0]       rd_acc,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [63:0]       wr_st,
  input  logic [63:0]       wr_acc
);

  logic [63:0] st_mem  [MAX_POINTS];
  logic [63:0] acc_mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      st_mem[waddr]  <= wr_st;
      acc_mem[waddr] <= wr_acc;
    end
  end

  // read returns the old entry on a same-cycle write; the pipeline forwards
  always_ff @(posedge clk) begin
    if (ren) begin
      rd_st  <= st_mem[raddr];
      rd_acc <= acc_mem[raddr];
    end
  end

endmodule

// ===== sv/rk4_pipe.sv =====
// Point pipeline: operand capture with forwarding, slope products, rounding,
// saturating sums, write-back and the result register. Depends on rk4_pkg.
module rk4_pipe #(
  parameter int MAX_POINTS    = 1024,
  parameter int FRACTION_BITS = 16,
  parameter int ADDR_W        = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [1:0]                  action,
  input  logic [rk4_pkg::IDX_W-1:0]   point_index,
  input  logic signed [31:0]          value_x,
  input  logic signed [31:0]          value_y,
  input  logic signed [31:0]          slope_x,
  input  logic signed [31:0]          slope_y,
  input  rk4_pkg::coef_t              coef,
  input  logic [63:0]                 rd_st,
  input  logic [63:0]                 rd_acc,
  output logic                        we,
  output logic [ADDR_W-1:0]           waddr,
  output logic [63:0]                 wr_st,
  output logic [63:0]                 wr_acc,
  output logic                        done,
  output logic signed [31:0]          new_x,
  output logic signed [31:0]          new_y,
  output logic                        saturated
);

  localparam logic signed [63:0] HALF    = 64'sd1 <<< (FRACTION_BITS - 1);
  localparam logic [31:0]        SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0]        SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic        flag;
    logic [31:0] nv;
    logic [31:0] acc;
  } lane_t;

  // round half up, drop fraction, clamp to 32 bits; {flag, value}
  function automatic logic [32:0] round_sat(logic signed [63:0] p);
    logic signed [63:0] r;
    r = (p + HALF) >>> FRACTION_BITS;
    if (r[63:31] == '0 || r[63:31] == '1) begin
      return {1'b0, r[31:0]};
    end
    return {1'b1, r[63] ? SAT_MIN : SAT_MAX};
  endfunction

  function automatic logic [32:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return {1'b1, s[32] ? SAT_MIN : SAT_MAX};
    end
    return {1'b0, s[31:0]};
  endfunction

  function automatic lane_t step_lane(rk4_pkg::action_t act, logic [31:0] st,
                                      logic [31:0] acc, logic signed [63:0] pn_full,
                                      logic signed [63:0] pa_full);
    logic [32:0] pn;
    logic [32:0] pa;
    logic [32:0] sa;
    logic [32:0] nw;
    logic [32:0] ac;
    logic [31:0] base;
    lane_t       res;
    pn   = round_sat(pn_full);
    pa   = round_sat(pa_full);
    sa   = sat_add(st, acc);
    base = (act == rk4_pkg::ACT_CORR2) ? sa[31:0] : st;
    nw   = sat_add(base, pn[31:0]);
    ac   = sat_add(acc, pa[31:0]);
    res.nv = nw[31:0];
    unique case (act)
      rk4_pkg::ACT_PRED1: begin
        res.acc  = pa[31:0];
        res.flag = pn[32] | nw[32] | pa[32];
      end
      rk4_pkg::ACT_CORR1, rk4_pkg::ACT_PRED2: begin
        res.acc  = ac[31:0];
        res.flag = pn[32] | nw[32] | pa[32] | ac[32];
      end
      rk4_pkg::ACT_CORR2: begin
        res.acc  = acc;
        res.flag = pn[32] | nw[32] | sa[32];
      end
    endcase
    return res;
  endfunction

  // stage 1: memory read data arrives
  logic                         s1_valid;
  rk4_pkg::action_t             s1_action;
  logic                         s1_in_range;
  logic [ADDR_W-1:0]            s1_addr;
  logic [63:0]                  s1_value;
  logic signed [31:0]           s1_slope_x;
  logic signed [31:0]           s1_slope_y;
  logic [rk4_pkg::COEF_W-1:0]   cn;
  logic [rk4_pkg::COEF_W-1:0]   ca;
  logic signed [31:0]           cn_s;
  logic signed [31:0]           ca_s;
  logic signed [63:0]           pnx;
  logic signed [63:0]           pny;
  logic signed [63:0]           pax;
  logic signed [63:0]           pay;
  logic                         fwd1;
  logic [63:0]                  st1;
  logic [63:0]                  acc1;

  // stage 2: arithmetic and write-back
  logic                         s2_valid;
  rk4_pkg::action_t             s2_action;
  logic                         s2_in_range;
  logic [ADDR_W-1:0]            s2_addr;
  logic [63:0]                  s2_st;
  logic [63:0]                  s2_acc;
  logic signed [63:0]           s2_pnx;
  logic signed [63:0]           s2_pny;
  logic signed [63:0]           s2_pax;
  logic signed [63:0]           s2_pay;
  logic                         fwd2;
  logic [63:0]                  st2;
  logic [63:0]                  acc2;
  lane_t                        lane_x;
  lane_t                        lane_y;

  // last write-back, registered for forwarding
  logic                         lw_valid;
  logic [ADDR_W-1:0]            lw_addr;
  logic [63:0]                  lw_st;
  logic [63:0]                  lw_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      lw_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      lw_valid <= we;
      done     <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action   <= rk4_pkg::action_t'(action);
      s1_in_range <= (32'(point_index) < 32'(MAX_POINTS));
      s1_addr     <= ADDR_W'(point_index);
      s1_value    <= {value_y, value_x};
      s1_slope_x  <= slope_x;
      s1_slope_y  <= slope_y;
    end
  end

  always_comb begin
    unique case (s1_action)
      rk4_pkg::ACT_PRED1: begin
        cn = coef.c2;
        ca = coef.c6;
      end
      rk4_pkg::ACT_CORR1: begin
        cn = coef.c2;
        ca = coef.c3;
      end
      rk4_pkg::ACT_PRED2: begin
        cn = coef.c1;
        ca = coef.c3;
      end
      rk4_pkg::ACT_CORR2: begin
        cn = coef.c6;
        ca = coef.c3;
      end
    endcase
  end

  assign cn_s = $signed({1'b0, cn});
  assign ca_s = $signed({1'b0, ca});
  assign pnx  = 64'(cn_s) * 64'(s1_slope_x);
  assign pny  = 64'(cn_s) * 64'(s1_slope_y);
  assign pax  = 64'(ca_s) * 64'(s1_slope_x);
  assign pay  = 64'(ca_s) * 64'(s1_slope_y);

  // the write-back that landed on the same edge as this read
  assign fwd1 = lw_valid && s1_in_range && (lw_addr == s1_addr);
  assign st1  = (s1_action == rk4_pkg::ACT_PRED1) ? s1_value :
                !s1_in_range ? 64'd0 : fwd1 ? lw_st : rd_st;
  assign acc1 = !s1_in_range ? 64'd0 : fwd1 ? lw_acc : rd_acc;

  always_ff @(posedge clk) begin
    s2_action   <= s1_action;
    s2_in_range <= s1_in_range;
    s2_addr     <= s1_addr;
    s2_st       <= st1;
    s2_acc      <= acc1;
    s2_pnx      <= pnx;
    s2_pny      <= pny;
    s2_pax      <= pax;
    s2_pay      <= pay;
  end

  // the previous item wrote at the edge that opened this cycle
  assign fwd2 = lw_valid && s2_in_range && (lw_addr == s2_addr);
  assign st2  = (fwd2 && s2_action != rk4_pkg::ACT_PRED1) ? lw_st : s2_st;
  assign acc2 = fwd2 ? lw_acc : s2_acc;

  assign lane_x = step_lane(s2_action, st2[31:0], acc2[31:0], s2_pnx, s2_pax);
  assign lane_y = step_lane(s2_action, st2[63:32], acc2[63:32], s2_pny, s2_pay);

  assign we     = s2_valid && s2_in_range;
  assign waddr  = s2_addr;
  assign wr_st  = st2;
  assign wr_acc = {lane_y.acc, lane_x.acc};

  always_ff @(posedge clk) begin
    lw_addr   <= waddr;
    lw_st     <= wr_st;
    lw_acc    <= wr_acc;
    new_x     <= $signed(lane_x.nv);
    new_y     <= $signed(lane_y.nv);
    saturated <= lane_x.flag | lane_y.flag;
  end

endmodule

// ===== sv/rk4_stage_update.sv =====
// RK4 stage update for 2D points: one stage of the classical scheme per beat.
// Channels: command beat on start/busy with action, point_index, value, slope.
// A beat is taken at a clock edge where start is high and busy is low.
// The result (new_x, new_y, saturated) shows for one cycle with done high after
// the stage 1, stage 2 and result registers; the receiver cannot hold it off.
// Throughput: one beat per cycle while busy is low. Each beat reads its point's
// start value and slope accumulator from a store with registered read data and
// writes both back; a last-write register forwards to beats on the same point.
// step_size is written with step_size_wen and takes effect after busy drops:
// the dt/6 and dt/3 multipliers hold busy high until their results register.
// Reset returns step_size to 1.0 and holds busy while the coefficients settle;
// the stores are not cleared, and a point must see stage 0 before any other
// stage. Beats in flight at reset are dropped.
// Depends on rk4_pkg, rk4_coef, rk4_mem, rk4_pipe.
module rk4_stage_update #(
  parameter int MAX_POINTS    = rk4_pkg::MAX_POINTS_DEF,
  parameter int FRACTION_BITS = rk4_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action,
  input  logic [rk4_pkg::IDX_W-1:0]   point_index,
  input  logic signed [31:0]          value_x,
  input  logic signed [31:0]          value_y,
  input  logic signed [31:0]          slope_x,
  input  logic signed [31:0]          slope_y,
  input  logic                        step_size_wen,
  input  logic [rk4_pkg::COEF_W-1:0]  step_size,
  output logic                        done,
  output logic signed [31:0]          new_x,
  output logic signed [31:0]          new_y,
  output logic                        saturated
);

  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  logic              accept;
  rk4_pkg::coef_t    coef;
  logic [63:0]       rd_st;
  logic [63:0]       rd_acc;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [63:0]       wr_st;
  logic [63:0]       wr_acc;

  assign accept = start && !busy;

  rk4_coef u_coef (
    .clk   (clk),
    .rst   (rst),
    .wen   (step_size_wen),
    .wdata (step_size),
    .coef  (coef),
    .busy  (busy)
  );

  rk4_mem #(
    .MAX_POINTS (MAX_POINTS),
    .ADDR_W     (ADDR_W)
  ) u_mem (
    .clk    (clk),
    .ren    (accept),
    .raddr  (ADDR_W'(point_index)),
    .rd_st  (rd_st),
    .rd_acc (rd_acc),
    .we     (we),
    .waddr  (waddr),
    .wr_st  (wr_st),
    .wr_acc (wr_acc)
  );

  rk4_pipe #(
    .MAX_POINTS    (MAX_POINTS),
    .FRACTION_BITS (FRACTION_BITS),
    .ADDR_W        (ADDR_W)
  ) u_pipe (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .action      (action),
    .point_index (point_index),
    .value_x     (value_x),
    .value_y     (value_y),
    .slope_x     (slope_x),
    .slope_y     (slope_y),
    .coef        (coef),
    .rd_st       (rd_st),
    .rd_acc      (rd_acc),
    .we          (we),
    .waddr       (waddr),
    .wr_st       (wr_st),
    .wr_acc      (wr_acc),
    .done        (done),
    .new_x       (new_x),
    .new_y       (new_y),
    .saturated   (saturated)
  );

endmodule

// ===== sv/rk4_chk.sv =====
// Port-level checks for rk4_stage_update: latency, no stray results, busy timing.
// Bound to the top level below; depends on no package items.
module rk4_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic step_size_wen,
  input logic done
);

  // every command beat is followed by a result on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result missing three cycles after a command beat");

  // no result without a matching earlier command beat
  a_no_stray: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, 3))
    else $error("result without a matching command beat");

  a_reset_busy: assert property (@(posedge clk)
    $past(rst) |-> (busy && !done))
    else $error("busy low or result shown right after reset");

  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    step_size_wen |=> busy)
    else $error("busy low while coefficients settle");

endmodule

bind rk4_stage_update rk4_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .step_size_wen (step_size_wen),
  .done          (done)
);
